// File: rtl/assert_macros.svh
// Assertion macros shared by the timeline calculator RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timeline calculator check failed");

// next-cycle implication
`define SPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timeline calculator check failed");

`endif

// File: rtl/spt_pkg.sv
// Types and constants of the stimulation pulse timeline calculator.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package spt_pkg;

  localparam int unsigned MarkW   = 16;
  localparam int unsigned AmpW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  typedef logic [MarkW-1:0] mark_t;

  localparam mark_t NEVER_MARK = 16'hffff;

  localparam int unsigned StatusShortBit    = 0;
  localparam int unsigned StatusUnbalanceBit = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETTLE_ENABLE   = 3'd0,
    REG_PRE_SETTLE      = 3'd1,
    REG_POST_SETTLE     = 3'd2,
    REG_RECOVERY_DELAY  = 3'd3,
    REG_RECOVERY_LENGTH = 3'd4
  } cfg_reg_e;

  localparam logic  RST_SETTLE_ENABLE   = 1'b1;
  localparam mark_t RST_PRE_SETTLE      = 16'd10;
  localparam mark_t RST_POST_SETTLE     = 16'd10;
  localparam mark_t RST_RECOVERY_DELAY  = 16'd10;
  localparam mark_t RST_RECOVERY_LENGTH = 16'd500;

  typedef struct packed {
    logic  settle_enable;
    mark_t pre_settle;
    mark_t post_settle;
    mark_t recovery_delay;
    mark_t recovery_length;
  } cfg_t;

  typedef struct packed {
    mark_t            lead_width;
    logic [AmpW-1:0]  lead_amp;
    mark_t            second_width;
    logic [AmpW-1:0]  second_amp;
    mark_t            dwell;
    mark_t            period;
    mark_t            start_delay;
  } item_t;

  typedef struct packed {
    mark_t phase_two_at;
    mark_t phase_three_at;
    mark_t stim_end_at;
    mark_t repeat_at;
    mark_t recovery_on_at;
    mark_t recovery_off_at;
    mark_t sequence_end_at;
    mark_t settle_on_at;
    mark_t settle_off_at;
    mark_t rep_settle_on_at;
    mark_t rep_settle_off_at;
  } marks_t;

endpackage

// File: rtl/spt_cfg_regs.sv
// Configuration register file of the timeline calculator.
// Depends on spt_pkg.
`timescale 1ns / 1ps

module spt_cfg_regs import spt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [CfgDatW-1:0] wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_reg_e'(wr_index_i))
        REG_SETTLE_ENABLE:   cfg_d.settle_enable   = wr_data_i[0];
        REG_PRE_SETTLE:      cfg_d.pre_settle      = wr_data_i;
        REG_POST_SETTLE:     cfg_d.post_settle     = wr_data_i;
        REG_RECOVERY_DELAY:  cfg_d.recovery_delay  = wr_data_i;
        REG_RECOVERY_LENGTH: cfg_d.recovery_length = wr_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_enable   <= RST_SETTLE_ENABLE;
      cfg_q.pre_settle      <= RST_PRE_SETTLE;
      cfg_q.post_settle     <= RST_POST_SETTLE;
      cfg_q.recovery_delay  <= RST_RECOVERY_DELAY;
      cfg_q.recovery_length <= RST_RECOVERY_LENGTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/spt_calc.sv
// Check of one pulse request and computation of its timeline marks.
// Depends on spt_pkg; purely combinational.
`timescale 1ns / 1ps

module spt_calc import spt_pkg::*; (
  input  item_t                item_i,
  input  cfg_t                 cfg_i,
  input  marks_t               held_i,
  output logic [StatusW-1:0]   status_o,
  output marks_t               marks_o
);

  localparam int unsigned WideW = MarkW + 4;
  localparam int unsigned ProdW = MarkW + AmpW;

  typedef logic [WideW-1:0] wide_t;

  wide_t                phase_sum;
  logic [ProdW-1:0]     lead_charge;
  logic [ProdW-1:0]     second_charge;
  wide_t                p2, p3, se, rep, ron, roff, seq_end;
  wide_t                se_post, rep_need;
  wide_t                st_w, pre_w, post_w;
  logic                 too_short;
  logic                 unbalanced;

  always_comb begin
    st_w   = {4'b0, item_i.start_delay};
    pre_w  = {4'b0, cfg_i.pre_settle};
    post_w = {4'b0, cfg_i.post_settle};

    phase_sum = {4'b0, item_i.lead_width} + {4'b0, item_i.dwell}
              + {4'b0, item_i.second_width};
    too_short = {4'b0, item_i.period} < phase_sum;

    lead_charge   = {{MarkW{1'b0}}, item_i.lead_amp} * {{AmpW{1'b0}}, item_i.lead_width};
    second_charge = {{MarkW{1'b0}}, item_i.second_amp} * {{AmpW{1'b0}}, item_i.second_width};
    unbalanced    = lead_charge != second_charge;

    p2      = st_w + {4'b0, item_i.lead_width};
    p3      = p2 + {4'b0, item_i.dwell};
    se      = p3 + {4'b0, item_i.second_width};
    rep     = st_w + {4'b0, item_i.period};
    ron     = se + {4'b0, cfg_i.recovery_delay};
    roff    = ron + {4'b0, cfg_i.recovery_length};
    seq_end = roff + wide_t'(1);
    se_post = se + post_w;
    rep_need = se_post + pre_w;

    status_o = '0;
    status_o[StatusShortBit]     = too_short;
    status_o[StatusUnbalanceBit] = unbalanced;

    marks_o = held_i;
    if (!too_short && !unbalanced) begin
      marks_o.phase_two_at    = p2[MarkW-1:0];
      marks_o.phase_three_at  = p3[MarkW-1:0];
      marks_o.stim_end_at     = se[MarkW-1:0];
      marks_o.repeat_at       = rep[MarkW-1:0];
      marks_o.recovery_on_at  = ron[MarkW-1:0];
      marks_o.recovery_off_at = roff[MarkW-1:0];
      marks_o.sequence_end_at = seq_end[MarkW-1:0];
      if (!cfg_i.settle_enable) begin
        marks_o.settle_on_at     = NEVER_MARK;
        marks_o.rep_settle_on_at = NEVER_MARK;
      end else begin
        marks_o.settle_on_at = (item_i.start_delay >= cfg_i.pre_settle) ?
                               (item_i.start_delay - cfg_i.pre_settle) : '0;
        if (rep < rep_need) begin
          marks_o.rep_settle_off_at = NEVER_MARK;
          marks_o.rep_settle_on_at  = NEVER_MARK;
        end else begin
          marks_o.rep_settle_off_at = se_post[MarkW-1:0];
          marks_o.rep_settle_on_at  = item_i.start_delay + item_i.period
                                      - cfg_i.pre_settle;
        end
        marks_o.settle_off_at = (se_post >= seq_end) ? seq_end[MarkW-1:0]
                                                     : se_post[MarkW-1:0];
      end
    end
  end

endmodule

// File: rtl/stim_pulse_timeline_calc_unit.sv
// Top level of the stimulation pulse timeline calculator.
// Depends on spt_pkg, spt_cfg_regs, spt_calc and assert_macros.svh.
//
//   channel | direction | handshake             | payload
//   in      | to block  | in_valid_i/in_stall_o | seven request fields
//   out     | from      | out_valid_o/out_stall_i | status and eleven marks
//   cfg     | to block  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while the result is not stalled; a result reaches the outputs through
// the input register, then the result register, with the check and mark adders between.
// Reset clears the configuration to its defaults and every held mark to zero.
// A stalled result holds; the input register still takes one more item behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stim_pulse_timeline_calc_unit import spt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mark_t              lead_width_i,
  input  logic [AmpW-1:0]    lead_amp_i,
  input  mark_t              second_width_i,
  input  logic [AmpW-1:0]    second_amp_i,
  input  mark_t              dwell_i,
  input  mark_t              period_i,
  input  mark_t              start_delay_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output mark_t              phase_two_at_o,
  output mark_t              phase_three_at_o,
  output mark_t              stim_end_at_o,
  output mark_t              repeat_at_o,
  output mark_t              recovery_on_at_o,
  output mark_t              recovery_off_at_o,
  output mark_t              sequence_end_at_o,
  output mark_t              settle_on_at_o,
  output mark_t              settle_off_at_o,
  output mark_t              rep_settle_on_at_o,
  output mark_t              rep_settle_off_at_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  cfg_t               cfg;
  item_t              item_q;
  logic               item_vld_q;
  logic               out_vld_q;
  logic [StatusW-1:0] status_q;
  logic [StatusW-1:0] status_d;
  marks_t             held_q;
  marks_t             held_d;
  logic               out_free;
  logic               advance;
  logic               in_take;

  assign cfg_ready_o = 1'b1;

  spt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  spt_calc u_calc (
    .item_i   (item_q),
    .cfg_i    (cfg),
    .held_i   (held_q),
    .status_o (status_d),
    .marks_o  (held_d)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = item_vld_q && out_free;
  assign in_stall_o = item_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.lead_width   <= lead_width_i;
      item_q.lead_amp     <= lead_amp_i;
      item_q.second_width <= second_width_i;
      item_q.second_amp   <= second_amp_i;
      item_q.dwell        <= dwell_i;
      item_q.period       <= period_i;
      item_q.start_delay  <= start_delay_i;
    end
    if (advance) begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      held_q     <= '0;
    end else begin
      if (in_take) begin
        item_vld_q <= 1'b1;
      end else if (advance) begin
        item_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        held_q    <= held_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_vld_q;
  assign status_o            = status_q;
  assign phase_two_at_o      = held_q.phase_two_at;
  assign phase_three_at_o    = held_q.phase_three_at;
  assign stim_end_at_o       = held_q.stim_end_at;
  assign repeat_at_o         = held_q.repeat_at;
  assign recovery_on_at_o    = held_q.recovery_on_at;
  assign recovery_off_at_o   = held_q.recovery_off_at;
  assign sequence_end_at_o   = held_q.sequence_end_at;
  assign settle_on_at_o      = held_q.settle_on_at;
  assign settle_off_at_o     = held_q.settle_off_at;
  assign rep_settle_on_at_o  = held_q.rep_settle_on_at;
  assign rep_settle_off_at_o = held_q.rep_settle_off_at;

  `SPT_ASSERT_NXT(a_held_idle, clk_i, rst_ni, !advance, $stable(held_q))
  `SPT_ASSERT_NXT(a_reject_keeps, clk_i, rst_ni, advance && (status_d != '0), $stable(held_q))
  `SPT_ASSERT_IMP(a_stall_needs_item, clk_i, rst_ni, in_stall_o, item_vld_q && out_vld_q)
  `SPT_ASSERT_NXT(a_settle_off_never, clk_i, rst_ni,
    advance && (status_d == '0) && !cfg.settle_enable, held_q.settle_on_at == NEVER_MARK)

endmodule
